[design/keyed_lru_resource_pool_defines.svh]
// assertion macros shared by the pool rtl
`ifndef KEYED_LRU_RESOURCE_POOL_DEFINES_SVH
`define KEYED_LRU_RESOURCE_POOL_DEFINES_SVH

// condition that holds at every edge out of reset
`define KRP_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define KRP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KRP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/krp_pkg.sv]
`default_nettype none

package krp_pkg;

    localparam int ENTRIES  = 16;
    localparam int MAX_TICK = 65535;

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int KEY_W    = 16;
    localparam int ID_W     = 16;
    localparam int TICK_W   = 16;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD     = 3'd0,
        REQ_BY_KEY  = 3'd1,
        REQ_ANY     = 3'd2,
        REQ_REMAP   = 3'd3,
        REQ_REMOVE  = 3'd4,
        REQ_RELEASE = 3'd5
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   res;
        logic [TICK_W-1:0] stamp;
    } entry_t;

    // one table entry as seen by the scan, in the cycle after its read is issued
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             ent_valid;
        logic             ent_busy;
        logic             ent_fresh;
        entry_t           ent;
    } scan_in_t;

    typedef struct packed {
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic              id_found;
        logic [IDX_W-1:0]  id_idx;
        logic [TICK_W-1:0] id_stamp;
        logic              busy_found;
        logic [IDX_W-1:0]  busy_idx;
        logic              grant_found;
        logic [IDX_W-1:0]  grant_idx;
        logic [KEY_W-1:0]  grant_key;
        logic [ID_W-1:0]   grant_res;
    } scan_res_t;

endpackage

`default_nettype wire

[design/krp_ram.sv]
`default_nettype none

module krp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/krp_scan.sv]
`default_nettype none

module krp_scan import krp_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             by_key,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic [ID_W-1:0]  id,
    input  wire scan_in_t         scan_in,
    output scan_res_t             scan_res
);

    scan_res_t         res_reg;
    logic [TICK_W-1:0] oldest_reg;

    logic              id_match;
    logic              cand;
    logic [TICK_W-1:0] stamp_eff;

    always_comb
    begin
        id_match  = scan_in.ent_valid && (scan_in.ent.res == id);
        cand      = scan_in.ent_valid && !scan_in.ent_busy &&
                    (!by_key || (scan_in.ent.key == key));
        // a stamp not written since the last tick restart counts as zero
        stamp_eff = scan_in.ent_fresh ? scan_in.ent.stamp : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg.free_found  <= 1'b0;
            res_reg.id_found    <= 1'b0;
            res_reg.busy_found  <= 1'b0;
            res_reg.grant_found <= 1'b0;
        end
        else if (start)
        begin
            res_reg.free_found  <= 1'b0;
            res_reg.id_found    <= 1'b0;
            res_reg.busy_found  <= 1'b0;
            res_reg.grant_found <= 1'b0;
            oldest_reg          <= TICK_W'(MAX_TICK);
        end
        else if (scan_in.valid)
        begin
            if (!scan_in.ent_valid && !res_reg.free_found)
            begin
                res_reg.free_found <= 1'b1;
                res_reg.free_idx   <= scan_in.idx;
            end
            if (id_match && !res_reg.id_found)
            begin
                res_reg.id_found <= 1'b1;
                res_reg.id_idx   <= scan_in.idx;
                res_reg.id_stamp <= scan_in.ent.stamp;
            end
            if (id_match && scan_in.ent_busy && !res_reg.busy_found)
            begin
                res_reg.busy_found <= 1'b1;
                res_reg.busy_idx   <= scan_in.idx;
            end
            // ties go to the later slot
            if (cand && (stamp_eff <= oldest_reg))
            begin
                res_reg.grant_found <= 1'b1;
                res_reg.grant_idx   <= scan_in.idx;
                res_reg.grant_key   <= scan_in.ent.key;
                res_reg.grant_res   <= scan_in.ent.res;
                oldest_reg          <= stamp_eff;
            end
        end
    end

    assign scan_res = res_reg;

endmodule

`default_nettype wire

[design/keyed_lru_resource_pool.sv]
// the scan makes one table read a cycle, covering every entry after accept
// a new item is taken only once the last one is committed; the single ram read port sets the scan length
// the next item is taken while a result still waits in the output register
// reset clears valid, busy and stamp-fresh bits at once and sets the tick to one
// the ram needs no clearing pass
`default_nettype none
`include "keyed_lru_resource_pool_defines.svh"

module keyed_lru_resource_pool import krp_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // key [15:0], resource_id [31:16]
    input  wire logic [2:0]  s_tuser,   // req_type [2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // granted_id [15:0]
    output logic      [1:0]  m_tuser    // status [1:0]
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        UPDATE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               eval_valid_reg;
    logic [IDX_W-1:0]   eval_idx_reg;
    req_t               req_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [ID_W-1:0]    id_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] busy_reg;
    logic [ENTRIES-1:0] fresh_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic               m_tvalid_reg;
    status_t            status_reg;
    logic [ID_W-1:0]    granted_reg;

    logic               accept;
    logic               issue;
    logic               commit;
    logic               by_key;
    entry_t             rd_entry;
    entry_t             wr_entry;
    scan_in_t           scan_in;
    scan_res_t          scan_res;

    logic               ram_we;
    logic [IDX_W-1:0]   tgt_idx;
    logic               set_valid;
    logic               clr_valid;
    logic               set_busy;
    logic               clr_busy;
    logic               set_fresh;
    logic               clr_fresh;
    logic               grant_ok;
    logic               restart;
    logic [TICK_W:0]    tick_sum;
    logic [TICK_W-1:0]  tick_next;
    status_t            status_next;
    logic [ID_W-1:0]    granted_next;

    assign s_tready = (state_reg == IDLE);
    assign accept   = s_tvalid && s_tready;
    assign issue    = (state_reg == SCAN) && (cnt_reg < CNT_W'(ENTRIES));
    assign commit   = (state_reg == UPDATE) && (!m_tvalid_reg || m_tready);
    assign by_key   = (req_reg == REQ_BY_KEY);

    krp_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_idx),
        .wdata (wr_entry),
        .re    (issue),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    always_comb
    begin
        scan_in.valid     = eval_valid_reg;
        scan_in.idx       = eval_idx_reg;
        scan_in.ent_valid = valid_reg[eval_idx_reg];
        scan_in.ent_busy  = busy_reg[eval_idx_reg];
        scan_in.ent_fresh = fresh_reg[eval_idx_reg];
        scan_in.ent       = rd_entry;
    end

    krp_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .by_key   (by_key),
        .key      (key_reg),
        .id       (id_reg),
        .scan_in  (scan_in),
        .scan_res (scan_res)
    );

    always_comb
    begin
        ram_we       = 1'b0;
        tgt_idx      = scan_res.grant_idx;
        wr_entry     = '{key: scan_res.grant_key, res: scan_res.grant_res, stamp: tick_reg};
        set_valid    = 1'b0;
        clr_valid    = 1'b0;
        set_busy     = 1'b0;
        clr_busy     = 1'b0;
        set_fresh    = 1'b0;
        clr_fresh    = 1'b0;
        grant_ok     = 1'b0;
        status_next  = ST_OK;
        granted_next = '0;
        case (req_reg)
            REQ_ADD:
            begin
                tgt_idx  = scan_res.free_idx;
                wr_entry = '{key: key_reg, res: id_reg, stamp: '0};
                if (scan_res.free_found)
                begin
                    ram_we    = 1'b1;
                    set_valid = 1'b1;
                    clr_busy  = 1'b1;
                    clr_fresh = 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            REQ_BY_KEY, REQ_ANY:
            begin
                if (scan_res.grant_found)
                begin
                    ram_we       = 1'b1;
                    set_busy     = 1'b1;
                    set_fresh    = 1'b1;
                    grant_ok     = 1'b1;
                    granted_next = scan_res.grant_res;
                end
                else
                begin
                    status_next = ST_NO_FREE;
                end
            end
            REQ_REMAP:
            begin
                tgt_idx  = scan_res.id_idx;
                wr_entry = '{key: key_reg, res: id_reg, stamp: scan_res.id_stamp};
                if (scan_res.id_found)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_REMOVE:
            begin
                tgt_idx = scan_res.id_idx;
                if (scan_res.id_found)
                begin
                    clr_valid = 1'b1;
                    clr_busy  = 1'b1;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_RELEASE:
            begin
                tgt_idx = scan_res.busy_idx;
                if (scan_res.busy_found)
                begin
                    clr_busy = 1'b1;
                end
                else if (!scan_res.id_found)
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        if (!commit)
        begin
            ram_we    = 1'b0;
            set_valid = 1'b0;
            clr_valid = 1'b0;
            set_busy  = 1'b0;
            clr_busy  = 1'b0;
            set_fresh = 1'b0;
            clr_fresh = 1'b0;
            grant_ok  = 1'b0;
        end
    end

    // tick advances on each grant and restarts once it reaches the limit
    always_comb
    begin
        tick_sum  = {1'b0, tick_reg} + 1'b1;
        restart   = grant_ok && (tick_sum >= (TICK_W + 1)'(MAX_TICK));
        tick_next = tick_reg;
        if (restart)
        begin
            tick_next = TICK_W'(1);
        end
        else if (grant_ok)
        begin
            tick_next = tick_sum[TICK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            cnt_reg        <= '0;
            eval_valid_reg <= 1'b0;
            valid_reg      <= '0;
            busy_reg       <= '0;
            fresh_reg      <= '0;
            tick_reg       <= TICK_W'(1);
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            eval_valid_reg <= issue;
            eval_idx_reg   <= cnt_reg[IDX_W-1:0];
            if (m_tvalid_reg && m_tready && !commit)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        req_reg   <= req_t'(s_tuser);
                        key_reg   <= s_tdata[15:0];
                        id_reg    <= s_tdata[31:16];
                        cnt_reg   <= '0;
                        state_reg <= SCAN;
                    end
                end
                SCAN:
                begin
                    if (issue)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (eval_valid_reg && (eval_idx_reg == IDX_W'(ENTRIES - 1)))
                    begin
                        state_reg <= UPDATE;
                    end
                end
                UPDATE:
                begin
                    if (commit)
                    begin
                        m_tvalid_reg <= 1'b1;
                        status_reg   <= status_next;
                        granted_reg  <= granted_next;
                        state_reg    <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
            if (set_valid)
            begin
                valid_reg[tgt_idx] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[tgt_idx] <= 1'b0;
            end
            if (set_busy)
            begin
                busy_reg[tgt_idx] <= 1'b1;
            end
            if (clr_busy)
            begin
                busy_reg[tgt_idx] <= 1'b0;
            end
            // a restart clears every stamp, the fresh grant included
            if (restart)
            begin
                fresh_reg <= '0;
            end
            else
            begin
                if (set_fresh)
                begin
                    fresh_reg[tgt_idx] <= 1'b1;
                end
                if (clr_fresh)
                begin
                    fresh_reg[tgt_idx] <= 1'b0;
                end
            end
            tick_reg <= tick_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = granted_reg;
    assign m_tuser  = status_reg;

    `KRP_ASSERT_ALWAYS(a_tick_range, (tick_reg != '0) && (tick_reg < TICK_W'(MAX_TICK)), "tick out of range")
    `KRP_ASSERT_NXT(a_grant_busy, grant_ok, busy_reg[$past(tgt_idx)], "granted slot not busy")
    `KRP_ASSERT_IMP(a_grant_zero, m_tvalid && (m_tuser != ST_OK), m_tdata == '0, "id on failed item")
    `KRP_ASSERT_IMP(a_eval_in_scan, eval_valid_reg, state_reg == SCAN, "table read outside scan")

endmodule

`default_nettype wire

[tb/keyed_lru_resource_pool_test.sv]
`timescale 1ns / 1ps

module keyed_lru_resource_pool_test;
    import krp_pkg::*;

    localparam int LATENCY     = ENTRIES + 3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 250;
    localparam int KEY_POOL_N  = 6;
    localparam int ID_POOL_N   = 20;
    localparam int DIR_ROWS    = 16;

    // request codes the block ignores
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef struct packed {
        status_t     status;
        logic [15:0] granted;
    } reply_t;

    typedef struct packed {
        logic [2:0]  req;
        logic [15:0] key;
        logic [15:0] id;
        logic [4:0]  reps;
        logic        fixed;
        status_t     status;
        logic [15:0] granted;
    } stim_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // key [15:0], resource_id [31:16]
    logic [2:0]  s_tuser  = '0;     // req_type [2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // granted_id [15:0]
    logic [1:0]  m_tuser;           // status [1:0]

    // typed expectation travels alongside the item
    logic        fixed_on      = 1'b0;
    status_t     fixed_status  = ST_OK;
    logic [15:0] fixed_granted = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int errors        = 0;
    int checked       = 0;
    int requests      = 0;
    int n_grant       = 0;
    int n_no_free     = 0;
    int n_not_found   = 0;
    int n_full        = 0;

    reply_t expected_replies [$];

    // shadow copy of the pool
    logic        pool_valid [ENTRIES] = '{default: 1'b0};
    logic [15:0] pool_key   [ENTRIES] = '{default: 16'h0};
    logic [15:0] pool_id    [ENTRIES] = '{default: 16'h0};
    logic        pool_busy  [ENTRIES] = '{default: 1'b0};
    logic [15:0] pool_stamp [ENTRIES] = '{default: 16'h0};
    logic [15:0] tick_now = 16'd1;

    logic [15:0] key_pool [KEY_POOL_N];
    logic [15:0] id_pool  [ID_POOL_N];

    stim_row_t directed [DIR_ROWS] = '{
        '{REQ_ANY,      16'h0000, 16'h0000, 5'd1,  1'b1, ST_NO_FREE,   16'h0},
        '{REQ_RELEASE,  16'h0000, 16'hFFFF, 5'd1,  1'b1, ST_NOT_FOUND, 16'h0},
        '{REQ_REMAP,    16'hFFFF, 16'h0000, 5'd1,  1'b1, ST_NOT_FOUND, 16'h0},
        '{REQ_ADD,      16'hFFFF, 16'hFFFF, 5'd1,  1'b1, ST_OK,        16'h0},
        '{REQ_ADD,      16'hFFFF, 16'h5A5A, 5'd1,  1'b1, ST_OK,        16'h0},
        '{REQ_BY_KEY,   16'hFFFF, 16'h0000, 5'd1,  1'b0, ST_OK,        16'h0},
        '{REQ_BY_KEY,   16'h0000, 16'h0000, 5'd1,  1'b1, ST_NO_FREE,   16'h0},
        '{REQ_RELEASE,  16'h0000, 16'h5A5A, 5'd1,  1'b0, ST_OK,        16'h0},
        // id present but not busy
        '{REQ_RELEASE,  16'h0000, 16'h5A5A, 5'd1,  1'b0, ST_OK,        16'h0},
        '{REQ_ANY,      16'h0000, 16'h0000, 5'd1,  1'b0, ST_OK,        16'h0},
        // remove of a busy entry
        '{REQ_REMOVE,   16'h0000, 16'hFFFF, 5'd1,  1'b0, ST_OK,        16'h0},
        '{REQ_REMAP,    16'h0000, 16'h5A5A, 5'd1,  1'b0, ST_OK,        16'h0},
        '{REQ_SPARE_HI, 16'hFFFF, 16'hFFFF, 5'd1,  1'b1, ST_OK,        16'h0},
        '{REQ_ADD,      16'h0000, 16'h0000, 5'd15, 1'b0, ST_OK,        16'h0},
        '{REQ_ADD,      16'h0001, 16'h0001, 5'd1,  1'b1, ST_FULL,      16'h0},
        // all stamps zero but one, tie goes to the top slot
        '{REQ_ANY,      16'h0000, 16'h0000, 5'd1,  1'b0, ST_OK,        16'h0}
    };

    keyed_lru_resource_pool u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic int find_slot(input logic [15:0] id, input bit need_busy);
        int slot;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && pool_valid[i] && pool_id[i] == id && (!need_busy || pool_busy[i]))
                slot = i;
        return slot;
    endfunction

    function automatic reply_t grant_oldest(input bit by_key, input logic [15:0] key);
        reply_t r;
        int     pick;
        int     oldest;
        r.status  = ST_NO_FREE;
        r.granted = '0;
        pick      = -1;
        oldest    = MAX_TICK;
        for (int i = 0; i < ENTRIES; i++)
            if (pool_valid[i] && !pool_busy[i] && (!by_key || pool_key[i] == key)
                && int'(pool_stamp[i]) <= oldest)
            begin
                pick   = i;
                oldest = int'(pool_stamp[i]);
            end
        if (pick >= 0)
        begin
            pool_stamp[pick] = tick_now;
            pool_busy[pick]  = 1'b1;
            r.status         = ST_OK;
            r.granted        = pool_id[pick];
            tick_now         = tick_now + 16'd1;
            if (int'(tick_now) >= MAX_TICK)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    pool_stamp[i] = '0;
                tick_now = 16'd1;
            end
        end
        return r;
    endfunction

    function automatic reply_t pool_apply(input logic [2:0] req, input logic [15:0] key,
                                          input logic [15:0] id);
        reply_t r;
        int     slot;
        r.status  = ST_OK;
        r.granted = '0;
        case (req)
            REQ_ADD:
            begin
                slot = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !pool_valid[i])
                        slot = i;
                if (slot < 0)
                    r.status = ST_FULL;
                else
                begin
                    pool_valid[slot] = 1'b1;
                    pool_key[slot]   = key;
                    pool_id[slot]    = id;
                    pool_busy[slot]  = 1'b0;
                    pool_stamp[slot] = '0;
                end
            end
            REQ_BY_KEY: r = grant_oldest(1'b1, key);
            REQ_ANY:    r = grant_oldest(1'b0, key);
            REQ_REMAP:
            begin
                slot = find_slot(id, 1'b0);
                if (slot < 0)
                    r.status = ST_NOT_FOUND;
                else
                    pool_key[slot] = key;
            end
            REQ_REMOVE:
            begin
                slot = find_slot(id, 1'b0);
                if (slot < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    pool_valid[slot] = 1'b0;
                    pool_busy[slot]  = 1'b0;
                end
            end
            REQ_RELEASE:
            begin
                slot = find_slot(id, 1'b1);
                if (slot >= 0)
                    pool_busy[slot] = 1'b0;
                else if (find_slot(id, 1'b0) < 0)
                    r.status = ST_NOT_FOUND;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        reply_t want;
        reply_t pred;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected result: status %0d, granted_id %h", m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== want.granted)
                    begin
                        $error("granted_id mismatch: expected %h, got %h",
                               want.granted, m_tdata);
                        errors++;
                    end
                    checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                pred = pool_apply(s_tuser, s_tdata[15:0], s_tdata[31:16]);
                if (fixed_on)
                begin
                    pred.status  = fixed_status;
                    pred.granted = fixed_granted;
                end
                requests++;
                case (pred.status)
                    ST_OK:        if (s_tuser == REQ_BY_KEY || s_tuser == REQ_ANY) n_grant++;
                    ST_NO_FREE:   n_no_free++;
                    ST_NOT_FOUND: n_not_found++;
                    ST_FULL:      n_full++;
                    default: ;
                endcase
                expected_replies.push_back(pred);
            end
        end
    end

    // receiver side: random stalls plus one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic offer_item(input logic [2:0] req, input logic [15:0] key,
                              input logic [15:0] id, input logic fixed,
                              input status_t st, input logic [15:0] gid);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 60)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid      <= 1'b1;
        s_tuser       <= req;
        s_tdata       <= {id, key};
        fixed_on      <= fixed;
        fixed_status  <= st;
        fixed_granted <= gid;
        do @(posedge clk); while (!s_tready);
    endtask

    // sender pauses until the pool has answered everything
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
    endtask

    function automatic int valid_count();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            n += int'(pool_valid[i]);
        return n;
    endfunction

    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        return 16'($urandom);
    endfunction

    // mostly ids that sit in the table, busy ones when asked
    function automatic logic [15:0] pick_id(input bit want_busy);
        logic [15:0] cands [$];
        for (int i = 0; i < ENTRIES; i++)
            if (pool_valid[i] && (!want_busy || pool_busy[i]))
                cands.push_back(pool_id[i]);
        if (cands.size() > 0 && $urandom_range(0, 99) < 80)
            return cands[$urandom_range(0, cands.size() - 1)];
        if ($urandom_range(0, 1))
            return id_pool[$urandom_range(0, ID_POOL_N - 1)];
        return 16'($urandom);
    endfunction

    task automatic run_traffic(input int count);
        int          sent;
        int          add_w;
        int          r;
        logic        noise;
        logic [2:0]  req;
        logic [15:0] key;
        logic [15:0] id;
        sent = 0;
        while (sent < count)
        begin
            add_w = (valid_count() < 4) ? 45 : (valid_count() < 12) ? 18 : 8;
            r     = $urandom_range(0, add_w + 81);
            noise = 1'b0;
            key   = pick_key();
            id    = pick_id(1'b0);
            if (r < add_w)
            begin
                req = REQ_ADD;
                id  = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, ID_POOL_N - 1)]
                                                   : 16'($urandom);
            end
            else if (r < add_w + 22)
                req = REQ_BY_KEY;
            else if (r < add_w + 36)
            begin
                req = REQ_ANY;
                key = 16'($urandom);
            end
            else if (r < add_w + 62)
            begin
                req = REQ_RELEASE;
                id  = pick_id(1'b1);
            end
            else if (r < add_w + 70)
                req = REQ_REMAP;
            else if (r < add_w + 80)
                req = REQ_REMOVE;
            else
            begin
                req   = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
                noise = 1'b1;
            end
            offer_item(req, key, id, 1'b0, ST_OK, 16'h0);
            if (!noise)
                sent++;
        end
    endtask

    initial
    begin
        for (int i = 0; i < KEY_POOL_N; i++)
            key_pool[i] = 16'($urandom);
        for (int i = 0; i < ID_POOL_N; i++)
            id_pool[i] = 16'($urandom);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            for (int k = 0; k < directed[i].reps; k++)
                offer_item(directed[i].req, directed[i].key, directed[i].id,
                           directed[i].fixed, directed[i].status, directed[i].granted);
        settle();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 63 : (phase == 3) ? 31 : 0;
            stall_pct     = (phase == 2) ? 63 : (phase == 3) ? 31 : 0;
            run_traffic(PHASE_ITEMS);
            settle();
            if (phase == 0)
            begin
                // output held off while items keep coming, input must back up
                hold_left = HOLD_CYCLES;
                run_traffic(30);
                settle();
            end
        end

        if (expected_replies.size() != 0)
        begin
            $error("%0d results never arrived", expected_replies.size());
            errors++;
        end
        $display("%0d requests, %0d results checked under four idle/stall mixes and a long hold",
                 requests, checked);
        $display("grants %0d, no free match %0d, id not found %0d, table full %0d",
                 n_grant, n_no_free, n_not_found, n_full);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
